// ===== design/bounded_set_table_core_assert.svh =====
// Assertion macros used by the design file bounded_set_table_core.sv.
`ifndef BOUNDED_SET_TABLE_CORE_ASSERT_SVH
`define BOUNDED_SET_TABLE_CORE_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define BST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define BST_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== design/bst_pkg.sv =====
package bst_pkg;

  // store geometry
  localparam int DEPTH  = 64;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // field widths
  localparam int VAL_W      = 32;
  localparam int CMD_W      = 2;
  localparam int STAT_W     = 3;
  localparam int OUTCNT_W   = 7;
  localparam int CFG_W      = 7;
  localparam int CMP_W      = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int M_TDATA_W  = 8;
  localparam int M_TUSER_W  = STAT_W + 1;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(64);

  // commands
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] ST_REMOVED   = 3'd3;
  localparam logic [STAT_W-1:0] ST_ABSENT    = 3'd4;
  localparam logic [STAT_W-1:0] ST_QUERY     = 3'd5;

endpackage

// ===== design/bst_ram.sv =====
// Simple dual-port RAM, one write and one registered read per cycle.
module bst_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/bounded_set_table_core.sv =====
// Bounded set of distinct 32-bit signed values, held in one RAM.
// Input channel s_*: one beat per command; s_tuser carries the command
// (insert, remove, membership query), s_tdata the value.
// Output channel m_*: exactly one result beat per command; m_tuser carries
// status and the member flag, m_tdata the element count after the command.
// cfg_we/cfg_wdata set the capacity limit; the limit in force is
// min(limit, DEPTH). Write it only while no command is in flight.
// Each command reads the stored entries one per cycle from slot 0 up to
// count-1, stopping at the first match, through the single RAM read port.
// After the scan the result register loads in DECIDE, or in MOVE for a
// successful remove, which first reads the last entry to refill the vacated
// slot. The next command is taken in the cycle after the result loads.
// The result register frees the input side: a new command is accepted while
// the previous result still waits; a stalled receiver holds only the
// final DECIDE or MOVE step of the following command.
// Reset: count clears to zero, limit returns to 64, no result pending.
// RAM contents are not cleared; only slots below count are ever read.
module bounded_set_table_core import bst_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_W-1:0]     cfg_wdata,     // capacity_limit
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [VAL_W-1:0]     s_tdata,       // [31:0] value
  input  logic [CMD_W-1:0]     s_tuser,       // [1:0] cmd
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,       // [6:0] element_count, [7] zero
  output logic [M_TUSER_W-1:0] m_tuser        // [2:0] status, [3] is_member
);

  `include "bounded_set_table_core_assert.svh"

  typedef enum logic [1:0] {IDLE, SCAN, DECIDE, MOVE} state_t;

  state_t             state;
  logic [CMD_W-1:0]   cmd_q;
  logic [VAL_W-1:0]   val_q;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [CFG_W-1:0]   limit;
  logic [CNT_W-1:0]   scan_idx;      // next slot to read
  logic               rd_pend;       // read data valid for rd_slot
  logic [ADDR_W-1:0]  rd_slot;
  logic               found;
  logic [ADDR_W-1:0]  slot;

  logic [STAT_W-1:0]   res_status;
  logic                res_member;
  logic [OUTCNT_W-1:0] res_count;

  // RAM port signals
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [VAL_W-1:0]   mem_wdata;
  logic               mem_re;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [VAL_W-1:0]   mem_rdata;

  logic               s_fire;
  logic               hit;
  logic               issue;
  logic               out_free;
  logic               out_load;
  logic               full;
  logic [CNT_W-1:0]   cnt_m1;
  logic [STAT_W-1:0]  status_next;

  bst_ram #(
    .WIDTH  (VAL_W),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  assign s_tready = (state == IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign cnt_m1   = count - CNT_W'(1);

  // full against min(limit, DEPTH)
  assign full = (CMP_W'(count) >= CMP_W'(limit)) || (count >= CNT_W'(DEPTH));

  // compare the word read last cycle; stop issuing once matched
  assign hit   = rd_pend && (mem_rdata == val_q);
  assign issue = (state == SCAN) && (scan_idx < count) && !hit;

  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = count[ADDR_W-1:0];
    mem_wdata   = val_q;
    mem_re      = issue;
    mem_raddr   = scan_idx[ADDR_W-1:0];
    count_next  = count;
    out_load    = 1'b0;
    status_next = ST_QUERY;
    unique case (state)
      DECIDE: begin
        if (cmd_q == CMD_REMOVE && found) begin
          // fetch the last entry to refill the vacated slot
          mem_re    = 1'b1;
          mem_raddr = cnt_m1[ADDR_W-1:0];
        end else if (out_free) begin
          out_load = 1'b1;
          case (cmd_q)
            CMD_INSERT: begin
              if (found) begin
                status_next = ST_DUPLICATE;
              end else if (full) begin
                status_next = ST_FULL;
              end else begin
                status_next = ST_INSERTED;
                mem_we      = 1'b1;
                count_next  = count + CNT_W'(1);
              end
            end
            CMD_REMOVE: status_next = ST_ABSENT;
            default:    status_next = ST_QUERY;   // query and spare code
          endcase
        end
      end
      MOVE: begin
        if (out_free) begin
          out_load    = 1'b1;
          status_next = ST_REMOVED;
          mem_we      = 1'b1;
          mem_waddr   = slot;
          mem_wdata   = mem_rdata;
          count_next  = cnt_m1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      count    <= '0;
      limit    <= CFG_RESET;
      rd_pend  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit <= cfg_wdata;
      end
      count   <= count_next;
      rd_pend <= issue;
      if (issue) begin
        scan_idx <= scan_idx + CNT_W'(1);
        rd_slot  <= scan_idx[ADDR_W-1:0];
      end

      // result register: reload only once the previous beat has gone
      if (out_load) begin
        m_tvalid   <= 1'b1;
        res_status <= status_next;
        res_member <= found;
        res_count  <= OUTCNT_W'(count_next);
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        IDLE: begin
          if (s_fire) begin
            cmd_q    <= s_tuser;
            val_q    <= s_tdata;
            found    <= 1'b0;
            scan_idx <= '0;
            state    <= (count == '0) ? DECIDE : SCAN;
          end
        end
        SCAN: begin
          if (hit) begin
            found <= 1'b1;
            slot  <= rd_slot;
            state <= DECIDE;
          end else if (scan_idx == count) begin
            // last compare done, no match
            state <= DECIDE;
          end
        end
        DECIDE: begin
          if (cmd_q == CMD_REMOVE && found) begin
            state <= MOVE;
          end else if (out_free) begin
            state <= IDLE;
          end
        end
        MOVE: begin
          if (out_free) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign m_tdata = M_TDATA_W'(res_count);
  assign m_tuser = {res_member, res_status};

  `BST_ASSERT(a_count_bound, count <= CNT_W'(DEPTH), "count exceeds store depth")
  `BST_ASSERT(a_count_with_result, (count_next == count) || out_load,
              "count changed without a result")
  `BST_ASSERT(a_write_with_result, !mem_we || out_load, "RAM written without a result")
  `BST_NEVER(a_accept_vs_result, s_fire && out_load,
             "command accepted while a result is being produced")

endmodule
